### hdl/icpu_pkg.sv
// ----------------------------------------------------------------------------
// icpu_pkg
// Shared types and constants of the indexed cel pixel unpacker.
// ----------------------------------------------------------------------------
package icpu_pkg;

  localparam int PALETTE_DEPTH = 256;
  localparam int PAL_AW        = $clog2(PALETTE_DEPTH);
  localparam int COLOUR_W      = 24;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 16;
  localparam int Q_DEPTH       = 4;
  localparam int Q_AW          = $clog2(Q_DEPTH);

  localparam logic [1:0] MODE_4BPP = 2'd0;
  localparam logic [1:0] MODE_8BPP = 2'd1;

  localparam logic FUNC_PALETTE = 1'b0;
  localparam logic FUNC_DATA    = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_DEPTH_MODE      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CEL_WIDTH       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CEL_HEIGHT      = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PALETTE_ENTRIES = 2'd3;

  typedef enum logic [1:0] {
    SRC_CLEAR,
    SRC_BLACK,
    SRC_PALETTE,
    SRC_DIRECT
  } pix_src_t;

  typedef struct packed {
    pix_src_t    src;
    logic [31:0] rgba;
    logic        row_end;
    logic        image_end;
    logic        last;
  } pix_req_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       row_end;
    logic       image_end;
    logic       last;
  } pix_out_t;

endpackage

### hdl/icpu_ram.sv
// ----------------------------------------------------------------------------
// icpu_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module icpu_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hdl/icpu_issue.sv
// ----------------------------------------------------------------------------
// icpu_issue
// Configuration registers, input handshake, byte gathering and pixel counters.
// Issues one pixel request per cycle while output queue credit allows, along with the palette read or write.
// ----------------------------------------------------------------------------
module icpu_issue (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [icpu_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [icpu_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                func,
  input  logic [7:0]                          entry_index,
  input  logic [icpu_pkg::COLOUR_W-1:0]       entry_colour,
  input  logic [7:0]                          data_byte,
  input  logic                                credit_ok,
  output logic                                req_valid,
  output icpu_pkg::pix_req_t                  req,
  output logic [icpu_pkg::PAL_AW-1:0]         rd_addr,
  output logic                                wr_en,
  output logic [icpu_pkg::PAL_AW-1:0]         wr_addr,
  output logic [icpu_pkg::COLOUR_W-1:0]       wr_data
);

  logic [1:0]  depth_mode;
  logic [15:0] cel_width;
  logic [15:0] cel_height;
  logic [8:0]  palette_entries;

  logic [15:0] column_count, column_count_next;
  logic [15:0] row_count, row_count_next;
  logic [23:0] gathered, gathered_next;
  logic [1:0]  byte_phase, byte_phase_next;
  logic        pending, pending_next;
  logic [3:0]  pend_nibble, pend_nibble_next;

  logic        accept;
  logic        fire;
  logic        pix_direct;
  logic        pix_last;
  logic [7:0]  pix_index;
  logic [16:0] width_ext, height_ext, col_inc, row_inc;
  logic        row_end_c, image_end_c;

  assign in_stall = pending || !credit_ok;
  assign accept   = in_valid && !in_stall;

  assign width_ext  = (cel_width == 16'd0) ? 17'h10000 : {1'b0, cel_width};
  assign height_ext = (cel_height == 16'd0) ? 17'h10000 : {1'b0, cel_height};
  assign col_inc    = {1'b0, column_count} + 17'd1;
  assign row_inc    = {1'b0, row_count} + 17'd1;
  assign row_end_c   = col_inc >= width_ext;
  assign image_end_c = row_end_c && (row_inc >= height_ext);

  always_comb begin
    fire             = 1'b0;
    pix_direct       = 1'b0;
    pix_last         = 1'b0;
    pix_index        = data_byte;
    gathered_next    = gathered;
    byte_phase_next  = byte_phase;
    pending_next     = pending;
    pend_nibble_next = pend_nibble;
    if (pending && credit_ok) begin
      fire         = 1'b1;
      pix_index    = {4'd0, pend_nibble};
      pix_last     = 1'b1;
      pending_next = 1'b0;
    end else if (accept && func == icpu_pkg::FUNC_DATA) begin
      if (depth_mode != icpu_pkg::MODE_4BPP && depth_mode != icpu_pkg::MODE_8BPP) begin
        if (byte_phase == 2'd3) begin
          fire            = 1'b1;
          pix_direct      = 1'b1;
          pix_last        = 1'b1;
          gathered_next   = 24'd0;
          byte_phase_next = 2'd0;
        end else begin
          case (byte_phase)
            2'd0:    gathered_next[7:0]   = data_byte;
            2'd1:    gathered_next[15:8]  = data_byte;
            default: gathered_next[23:16] = data_byte;
          endcase
          byte_phase_next = byte_phase + 2'd1;
        end
      end else begin
        gathered_next   = 24'd0;
        byte_phase_next = 2'd0;
        fire            = 1'b1;
        if (depth_mode == icpu_pkg::MODE_8BPP) begin
          pix_last = 1'b1;
        end else begin
          pix_index = {4'd0, data_byte[7:4]};
          if (!row_end_c) begin
            pending_next     = 1'b1;
            pend_nibble_next = data_byte[3:0];
          end
        end
      end
    end
  end

  always_comb begin
    column_count_next = column_count;
    row_count_next    = row_count;
    if (fire) begin
      if (row_end_c) begin
        column_count_next = 16'd0;
        row_count_next    = image_end_c ? 16'd0 : row_inc[15:0];
      end else begin
        column_count_next = col_inc[15:0];
      end
    end
  end

  always_comb begin
    req.rgba      = {gathered, data_byte};
    req.row_end   = row_end_c;
    req.image_end = image_end_c;
    req.last      = pix_last || row_end_c;
    if (pix_direct) begin
      req.src = icpu_pkg::SRC_DIRECT;
    end else if (pix_index == 8'd0) begin
      req.src = icpu_pkg::SRC_CLEAR;
    end else if ({1'b0, pix_index} < palette_entries &&
                 {1'b0, pix_index} < 9'(icpu_pkg::PALETTE_DEPTH)) begin
      req.src = icpu_pkg::SRC_PALETTE;
    end else begin
      req.src = icpu_pkg::SRC_BLACK;
    end
  end

  assign req_valid = fire;
  assign rd_addr   = pix_index[icpu_pkg::PAL_AW-1:0];
  assign wr_en     = accept && func == icpu_pkg::FUNC_PALETTE &&
                     {1'b0, entry_index} < 9'(icpu_pkg::PALETTE_DEPTH);
  assign wr_addr   = entry_index[icpu_pkg::PAL_AW-1:0];
  assign wr_data   = entry_colour;

  always_ff @(posedge clk) begin
    if (rst) begin
      depth_mode      <= icpu_pkg::MODE_8BPP;
      cel_width       <= 16'd1;
      cel_height      <= 16'd1;
      palette_entries <= 9'd256;
      column_count    <= 16'd0;
      row_count       <= 16'd0;
      gathered        <= 24'd0;
      byte_phase      <= 2'd0;
      pending         <= 1'b0;
      pend_nibble     <= 4'd0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          icpu_pkg::REG_DEPTH_MODE:      depth_mode      <= cfg_data[1:0];
          icpu_pkg::REG_CEL_WIDTH:       cel_width       <= cfg_data;
          icpu_pkg::REG_CEL_HEIGHT:      cel_height      <= cfg_data;
          icpu_pkg::REG_PALETTE_ENTRIES: palette_entries <= cfg_data[8:0];
          default: ;
        endcase
      end
      column_count <= column_count_next;
      row_count    <= row_count_next;
      gathered     <= gathered_next;
      byte_phase   <= byte_phase_next;
      pending      <= pending_next;
      pend_nibble  <= pend_nibble_next;
    end
  end

endmodule

### hdl/icpu_outq.sv
// ----------------------------------------------------------------------------
// icpu_outq
// Aligns pixel requests with the palette read data, resolves the final colour
// and queues finished pixels for the output channel.
// ----------------------------------------------------------------------------
module icpu_outq (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  input  icpu_pkg::pix_req_t            req,
  input  logic [icpu_pkg::COLOUR_W-1:0] rd_data,
  output logic                          credit_ok,
  output logic                          out_valid,
  input  logic                          out_stall,
  output icpu_pkg::pix_out_t            out_pix
);

  logic                   s1_valid;
  icpu_pkg::pix_req_t     s1_req;
  icpu_pkg::pix_out_t     resolved;
  icpu_pkg::pix_out_t     queue [icpu_pkg::Q_DEPTH];
  logic [icpu_pkg::Q_AW-1:0] wr_ptr, rd_ptr;
  logic [icpu_pkg::Q_AW:0]   count;
  logic                   pop;

  always_comb begin
    resolved.row_end   = s1_req.row_end;
    resolved.image_end = s1_req.image_end;
    resolved.last      = s1_req.last;
    case (s1_req.src)
      icpu_pkg::SRC_BLACK: begin
        {resolved.red, resolved.green, resolved.blue, resolved.alpha} = {24'd0, 8'd255};
      end
      icpu_pkg::SRC_PALETTE: begin
        {resolved.red, resolved.green, resolved.blue, resolved.alpha} = {rd_data, 8'd255};
      end
      icpu_pkg::SRC_DIRECT: begin
        resolved.red   = s1_req.rgba[31:24];
        resolved.green = s1_req.rgba[23:16];
        resolved.blue  = s1_req.rgba[15:8];
        resolved.alpha = s1_req.rgba[7:0];
      end
      default: begin
        {resolved.red, resolved.green, resolved.blue, resolved.alpha} = 32'd0;
      end
    endcase
  end

  assign out_valid = count != '0;
  assign out_pix   = queue[rd_ptr];
  assign pop       = out_valid && !out_stall;
  assign credit_ok = ({{icpu_pkg::Q_AW{1'b0}}, s1_valid} + count) <
                     (icpu_pkg::Q_AW + 1)'(icpu_pkg::Q_DEPTH - 1) + 1'b1;

  always_ff @(posedge clk) begin
    s1_req <= req;
    if (s1_valid) begin
      queue[wr_ptr] <= resolved;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      wr_ptr   <= '0;
      rd_ptr   <= '0;
      count    <= '0;
    end else begin
      s1_valid <= req_valid;
      if (s1_valid) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + {{icpu_pkg::Q_AW{1'b0}}, s1_valid} - {{icpu_pkg::Q_AW{1'b0}}, pop};
    end
  end

endmodule

### hdl/indexed_cel_pixel_unpacker.sv
// ----------------------------------------------------------------------------
// indexed_cel_pixel_unpacker
// Unpacks 4, 8 and 32 bit cel row bytes into RGBA pixels, 4 and 8 bit through a palette.
// ----------------------------------------------------------------------------
// A palette write or an 8 bpp byte is taken every cycle, and a 32 bpp byte
// every cycle with one pixel per four bytes, while the output queue has room.
// A 4 bpp byte that gives two pixels stalls the input while its second pixel
// issues, as the palette RAM has one read port and the output moves one pixel
// a cycle. A pixel passes a registered read stage into a four-entry output
// queue, so input flows while the output stalls until it fills. The palette
// needs no clearing if software writes each entry it uses; nothing checks it.
module indexed_cel_pixel_unpacker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [icpu_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [icpu_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              func,
  input  logic [7:0]                        entry_index,
  input  logic [icpu_pkg::COLOUR_W-1:0]     entry_colour,
  input  logic [7:0]                        data_byte,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [7:0]                        red,
  output logic [7:0]                        green,
  output logic [7:0]                        blue,
  output logic [7:0]                        alpha,
  output logic                              row_end,
  output logic                              image_end,
  output logic                              last_of_item
);

  logic                              credit_ok;
  logic                              req_valid;
  icpu_pkg::pix_req_t                req;
  logic [icpu_pkg::PAL_AW-1:0]       rd_addr;
  logic                              wr_en;
  logic [icpu_pkg::PAL_AW-1:0]       wr_addr;
  logic [icpu_pkg::COLOUR_W-1:0]     wr_data;
  logic [icpu_pkg::COLOUR_W-1:0]     rd_data;
  icpu_pkg::pix_out_t                out_pix;

  icpu_issue u_issue (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .func         (func),
    .entry_index  (entry_index),
    .entry_colour (entry_colour),
    .data_byte    (data_byte),
    .credit_ok    (credit_ok),
    .req_valid    (req_valid),
    .req          (req),
    .rd_addr      (rd_addr),
    .wr_en        (wr_en),
    .wr_addr      (wr_addr),
    .wr_data      (wr_data)
  );

  icpu_ram #(
    .WIDTH (icpu_pkg::COLOUR_W),
    .DEPTH (icpu_pkg::PALETTE_DEPTH)
  ) u_palette (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  icpu_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req       (req),
    .rd_data   (rd_data),
    .credit_ok (credit_ok),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_pix   (out_pix)
  );

  assign red          = out_pix.red;
  assign green        = out_pix.green;
  assign blue         = out_pix.blue;
  assign alpha        = out_pix.alpha;
  assign row_end      = out_pix.row_end;
  assign image_end    = out_pix.image_end;
  assign last_of_item = out_pix.last;

endmodule

### hdl/icpu_checker.sv
// ----------------------------------------------------------------------------
// icpu_checker
// Port-level checks of the indexed cel pixel unpacker, bound to the top level.
// ----------------------------------------------------------------------------
module icpu_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] red,
  input logic [7:0] green,
  input logic [7:0] blue,
  input logic [7:0] alpha,
  input logic       row_end,
  input logic       image_end,
  input logic       last_of_item
);

  a_image_end_on_row_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && image_end |-> row_end)
    else $error("Image end without row end.");

  a_row_end_ends_word: assert property (@(posedge clk) disable iff (rst)
    out_valid && row_end |-> last_of_item)
    else $error("Row end on a pixel that is not the last of its word.");

  a_empty_after_reset: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("Output valid right after reset.");

  a_stalled_word_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable({red, green, blue, alpha,
                                                     row_end, image_end, last_of_item}))
    else $error("Stalled output word changed.");

endmodule

bind indexed_cel_pixel_unpacker icpu_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .red          (red),
  .green        (green),
  .blue         (blue),
  .alpha        (alpha),
  .row_end      (row_end),
  .image_end    (image_end),
  .last_of_item (last_of_item)
);

### tb/cel_pixel_check_pkg.sv
// ----------------------------------------------------------------------------
// cel_pixel_check_pkg
// Predicts the RGBA pixels of the indexed cel pixel unpacker and checks them.
// ----------------------------------------------------------------------------
// The predictor keeps its own palette, register copies and row, cel and gather
// counters. It is told of every accepted input word and queues the pixels that
// word causes, then compares each accepted output pixel with the oldest one.
// ----------------------------------------------------------------------------
package cel_pixel_check_pkg;
  import icpu_pkg::*;

  localparam logic [1:0] MODE_BGRA  = 2'd2;
  localparam logic [1:0] MODE_SPARE = 2'd3;

  class cel_pixel_predictor;
    logic [1:0]          depth_mode;
    logic [15:0]         cel_width;
    logic [15:0]         cel_height;
    logic [8:0]          palette_entries;
    logic [COLOUR_W-1:0] palette [PALETTE_DEPTH];
    logic [15:0]         column_count;
    logic [15:0]         row_count;
    logic [23:0]         gathered;
    logic [1:0]          byte_phase;
    pix_out_t            pending_pixels[$];
    int                  errors;
    int                  pixels_checked;

    function new();
      depth_mode      = MODE_8BPP;
      cel_width       = 16'd1;
      cel_height      = 16'd1;
      palette_entries = 9'd256;
      column_count    = '0;
      row_count       = '0;
      gathered        = '0;
      byte_phase      = '0;
      errors          = 0;
      pixels_checked  = 0;
      foreach (palette[i]) palette[i] = '0;
    endfunction

    function void write_register(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
      case (index)
        REG_DEPTH_MODE:      depth_mode = data[1:0];
        REG_CEL_WIDTH:       cel_width = data;
        REG_CEL_HEIGHT:      cel_height = data;
        REG_PALETTE_ENTRIES: palette_entries = data[8:0];
        default: ;
      endcase
    endfunction

    function bit push_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic [7:0] a,
                            bit last);
      int unsigned w;
      int unsigned h;
      pix_out_t    p;
      w = (cel_width == 0) ? 32'd65536 : 32'(cel_width);
      h = (cel_height == 0) ? 32'd65536 : 32'(cel_height);
      p.red       = r;
      p.green     = g;
      p.blue      = b;
      p.alpha     = a;
      p.row_end   = 1'b0;
      p.image_end = 1'b0;
      if (32'(column_count) + 1 >= w) begin
        p.row_end    = 1'b1;
        column_count = '0;
        if (32'(row_count) + 1 >= h) begin
          p.image_end = 1'b1;
          row_count   = '0;
        end else begin
          row_count = row_count + 16'd1;
        end
      end else begin
        column_count = column_count + 16'd1;
      end
      p.last = last | p.row_end;
      pending_pixels.push_back(p);
      return p.row_end;
    endfunction

    function bit push_index(logic [7:0] index, bit last);
      logic [COLOUR_W-1:0] c;
      c = '0;
      if (index == 0) return push_pixel(8'h00, 8'h00, 8'h00, 8'h00, last);
      if (9'(index) < palette_entries && 32'(index) < PALETTE_DEPTH) c = palette[index];
      return push_pixel(c[23:16], c[15:8], c[7:0], 8'hFF, last);
    endfunction

    function void note_word(logic func, logic [7:0] slot, logic [COLOUR_W-1:0] colour,
                            logic [7:0] data);
      if (func == FUNC_PALETTE) begin
        palette[slot] = colour;
        return;
      end
      if (depth_mode == MODE_BGRA || depth_mode == MODE_SPARE) begin
        if (byte_phase != 2'd3) begin
          gathered[8*byte_phase +: 8] = data;
          byte_phase = byte_phase + 2'd1;
          return;
        end
        void'(push_pixel(gathered[23:16], gathered[15:8], gathered[7:0], data, 1'b1));
        gathered   = '0;
        byte_phase = '0;
        return;
      end
      gathered   = '0;
      byte_phase = '0;
      if (depth_mode == MODE_8BPP) begin
        void'(push_index(data, 1'b1));
        return;
      end
      if (!push_index({4'd0, data[7:4]}, 1'b0)) void'(push_index({4'd0, data[3:0]}, 1'b1));
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        errors++;
        $error("%s: expected %0d, got %0d", name, want, got);
      end
    endfunction

    function void check_pixel(pix_out_t got);
      pix_out_t want;
      if (pending_pixels.size() == 0) begin
        errors++;
        $error("pixel %h arrived with no pixel expected", got);
        return;
      end
      want = pending_pixels.pop_front();
      pixels_checked++;
      compare_field("red", want.red, got.red);
      compare_field("green", want.green, got.green);
      compare_field("blue", want.blue, got.blue);
      compare_field("alpha", want.alpha, got.alpha);
      compare_field("row_end", want.row_end, got.row_end);
      compare_field("image_end", want.image_end, got.image_end);
      compare_field("last_of_item", want.last, got.last);
    endfunction
  endclass

endpackage

### tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking test of the indexed cel pixel unpacker.
// ----------------------------------------------------------------------------
// A short directed sequence covers the depth modes, odd-width rows, the
// transparent and out-of-range indexes and a dropped 32-bit gather. Random
// phases follow under changing register settings, with bursty input and a
// stalling output, and every output pixel is checked against a prediction.
// ----------------------------------------------------------------------------
module tb;
  import icpu_pkg::*;
  import cel_pixel_check_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 8;
  localparam int PHASES       = 12;
  localparam int PHASE_WORDS  = 105;

  logic                  clk;
  logic                  rst;
  logic                  cfg_write;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_stall;
  logic                  func;
  logic [7:0]            entry_index;
  logic [COLOUR_W-1:0]   entry_colour;
  logic [7:0]            data_byte;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [7:0]            red;
  logic [7:0]            green;
  logic [7:0]            blue;
  logic [7:0]            alpha;
  logic                  row_end;
  logic                  image_end;
  logic                  last_of_item;

  cel_pixel_predictor cel_pixels = new();
  bit                 palette_written [PALETTE_DEPTH];
  int                 burst_left = 0;
  bit                 sender_gaps = 1'b1;
  int                 words_sent = 0;
  int                 settings_used = 0;
  int                 cycle_count = 0;
  int                 stall_tick = 0;
  int                 stall_style = 0;
  int                 stall_run = 0;
  bit                 stall_on = 1'b0;

  indexed_cel_pixel_unpacker u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .func         (func),
    .entry_index  (entry_index),
    .entry_colour (entry_colour),
    .data_byte    (data_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .red          (red),
    .green        (green),
    .blue         (blue),
    .alpha        (alpha),
    .row_end      (row_end),
    .image_end    (image_end),
    .last_of_item (last_of_item)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("indexed_cel_pixel_unpacker test failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (stall_tick % 256 == 0) stall_style = $urandom_range(0, 2);
    stall_tick++;
    case (stall_style)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 99) < 35);
      default: begin
        if (stall_run == 0) begin
          stall_on  = !stall_on;
          stall_run = $urandom_range(1, 12);
        end
        stall_run--;
        out_stall <= stall_on;
      end
    endcase
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      cel_pixels.check_pixel(pix_out_t'({red, green, blue, alpha, row_end, image_end,
                                         last_of_item}));
  end

  task automatic send_word(logic f, logic [7:0] slot, logic [COLOUR_W-1:0] colour,
                           logic [7:0] data);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (sender_gaps) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
    burst_left--;
    in_valid     <= 1'b1;
    func         <= f;
    entry_index  <= slot;
    entry_colour <= colour;
    data_byte    <= data;
    do @(posedge clk); while (in_stall);
    cel_pixels.note_word(f, slot, colour, data);
    if (f == FUNC_PALETTE) palette_written[slot] = 1'b1;
    words_sent++;
  endtask

  task automatic write_palette(logic [7:0] slot, logic [COLOUR_W-1:0] colour);
    send_word(FUNC_PALETTE, slot, colour, 8'($urandom));
  endtask

  task automatic ensure_slot(logic [7:0] index);
    if (index != 0 && 9'(index) < cel_pixels.palette_entries && !palette_written[index])
      write_palette(index, COLOUR_W'($urandom));
  endtask

  task automatic send_pixel_byte(logic [7:0] data);
    if (cel_pixels.depth_mode == MODE_4BPP) begin
      ensure_slot({4'd0, data[7:4]});
      ensure_slot({4'd0, data[3:0]});
    end else if (cel_pixels.depth_mode == MODE_8BPP) begin
      ensure_slot(data);
    end
    send_word(FUNC_DATA, 8'($urandom), COLOUR_W'($urandom), data);
  endtask

  task automatic wait_idle();
    in_valid   <= 1'b0;
    burst_left = 0;
    while (cel_pixels.pending_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic apply_settings(logic [1:0] mode, logic [15:0] width, logic [15:0] height,
                                logic [8:0] entries);
    logic [CFG_IDX_W-1:0]  regs [4];
    logic [CFG_DATA_W-1:0] values [4];
    regs   = '{REG_DEPTH_MODE, REG_CEL_WIDTH, REG_CEL_HEIGHT, REG_PALETTE_ENTRIES};
    values = '{16'(mode), width, height, 16'(entries)};
    wait_idle();
    for (int i = 0; i < 4; i++) begin
      cfg_write <= 1'b1;
      cfg_index <= regs[i];
      cfg_data  <= values[i];
      @(posedge clk);
      cel_pixels.write_register(regs[i], values[i]);
    end
    cfg_write <= 1'b0;
    settings_used++;
  endtask

  function automatic logic [15:0] pick_size();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 16'($urandom);
    if (r == 1) return 16'hFFFF;
    if (r == 2) return 16'd0;
    return 16'($urandom_range(1, 9));
  endfunction

  task automatic run_phase(int words);
    for (int i = 0; i < words; i++) begin
      if ($urandom_range(0, 99) < 10) write_palette(8'($urandom), COLOUR_W'($urandom));
      else send_pixel_byte(8'($urandom));
    end
  endtask

  initial begin
    rst          <= 1'b1;
    cfg_write    <= 1'b0;
    cfg_index    <= REG_DEPTH_MODE;
    cfg_data     <= '0;
    in_valid     <= 1'b0;
    func         <= FUNC_PALETTE;
    entry_index  <= '0;
    entry_colour <= '0;
    data_byte    <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    write_palette(8'd0, 24'hFFFFFF);
    write_palette(8'd1, 24'h000000);
    write_palette(8'd15, 24'hA5C3E1);
    write_palette(8'd255, 24'hFFFFFF);
    send_pixel_byte(8'h00);
    send_pixel_byte(8'hFF);
    send_pixel_byte(8'h01);
    send_pixel_byte(8'h0F);

    apply_settings(MODE_4BPP, 16'd3, 16'd2, 9'd16);
    send_pixel_byte(8'hF1);
    send_pixel_byte(8'h10);
    send_pixel_byte(8'hFF);
    send_pixel_byte(8'h0F);

    apply_settings(MODE_8BPP, 16'd2, 16'd1, 9'd16);
    send_pixel_byte(8'hFF);
    send_pixel_byte(8'h10);

    apply_settings(MODE_BGRA, 16'd1, 16'd1, 9'd256);
    send_pixel_byte(8'h11);
    send_pixel_byte(8'h22);
    send_pixel_byte(8'h33);
    send_pixel_byte(8'h44);
    send_pixel_byte(8'hAA);
    send_pixel_byte(8'hBB);
    apply_settings(MODE_8BPP, 16'd1, 16'd1, 9'd256);
    send_pixel_byte(8'h01);
    apply_settings(MODE_SPARE, 16'd2, 16'd2, 9'd256);
    send_pixel_byte(8'h00);
    send_pixel_byte(8'hFF);
    send_pixel_byte(8'h80);
    send_pixel_byte(8'h7F);

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: apply_settings(MODE_4BPP, 16'd1, 16'd1, 9'd256);
        1: apply_settings(MODE_BGRA, 16'd0, 16'd0, 9'd0);
        2: apply_settings(MODE_SPARE, 16'hFFFF, 16'hFFFF, 9'd256);
        3: apply_settings(MODE_8BPP, 16'hFFFF, 16'd0, 9'd0);
        4: apply_settings(MODE_4BPP, 16'd5, 16'd3, 9'd256);
        default: begin
          apply_settings(2'($urandom_range(0, 3)), pick_size(), pick_size(),
                         ($urandom_range(0, 1) != 0) ? 9'd256 : 9'($urandom_range(0, 256)));
        end
      endcase
      sender_gaps = ($urandom_range(0, 3) != 0);
      run_phase(PHASE_WORDS);
    end

    wait_idle();
    $display("Sent %0d words under %0d register settings and compared %0d pixels.",
             words_sent, settings_used, cel_pixels.pixels_checked);
    if (cel_pixels.errors == 0 && cel_pixels.pending_pixels.size() == 0) begin
      $display("indexed_cel_pixel_unpacker test passed");
    end else begin
      $display("indexed_cel_pixel_unpacker test failed");
    end
    $finish;
  end

endmodule

### filelist.f
hdl/icpu_pkg.sv
hdl/icpu_ram.sv
hdl/icpu_issue.sv
hdl/icpu_outq.sv
hdl/indexed_cel_pixel_unpacker.sv
hdl/icpu_checker.sv
tb/cel_pixel_check_pkg.sv
tb/tb.sv
